### src/assert_macros.svh
// Assertion macros shared by the block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed");
`endif

### src/rlrr_pkg.sv
// Package: types and constants of the rate limited round robin picker
`timescale 1ns / 1ps
package rlrr_pkg;
  localparam int MAX_STREAMS = 8;
  localparam int IDX_W = 3;
  localparam int CNT_W = 4;
  localparam int TIME_W = 40;
  localparam int IV_W = 10;
  localparam int DIV_STEPS = 10;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;
  localparam logic [1:0] MODE_POLL = 2'd2;
  localparam logic [1:0] MODE_DONE = 2'd3;

  localparam logic [1:0] CFG_TTL = 2'd0;
  localparam logic [1:0] CFG_DFPS = 2'd1;
  localparam logic [1:0] CFG_MAXDEG = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_LOAD, ST_SCAN, ST_MUL, ST_CHECK, ST_EXPIRE, ST_DONE
  } state_t;

  typedef struct packed {
    logic init;
    logic div_step;
    logic load_write;
    logic frame_write;
    logic scan_read;
    logic mul;
    logic check;
    logic expire;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic scan_last;
    logic cand_ok;
    logic pending;
  } stat_t;
endpackage

### src/rlrr_ctrl.sv
// Controller state machine of the picker
`timescale 1ns / 1ps
module rlrr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       mode,
  input  rlrr_pkg::stat_t  stat,
  output logic             busy,
  output rlrr_pkg::cmd_t   cmd
);
  import rlrr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (mode)
            MODE_LOAD: state_nxt = ST_DIV;
            MODE_FRAME: state_nxt = ST_IDLE;
            MODE_POLL: state_nxt = stat.pending ? ST_DONE : ST_SCAN;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DIV: begin
        if (stat.div_last) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: state_nxt = ST_IDLE;
      ST_SCAN: state_nxt = stat.scan_last ? ST_EXPIRE : ST_MUL;
      ST_MUL: state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = stat.cand_ok ? ST_IDLE : ST_SCAN;
      ST_EXPIRE: state_nxt = ST_IDLE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cmd.init = start;
        cmd.frame_write = start && (mode == MODE_FRAME);
      end
      ST_DIV: cmd.div_step = 1'b1;
      ST_LOAD: cmd.load_write = 1'b1;
      ST_SCAN: cmd.scan_read = 1'b1;
      ST_MUL: cmd.mul = 1'b1;
      ST_CHECK: cmd.check = 1'b1;
      ST_EXPIRE: cmd.expire = 1'b1;
      ST_DONE: cmd.done = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

### src/rlrr_dp.sv
// Datapath of the picker: entry table, divider, scan and result registers
`timescale 1ns / 1ps
module rlrr_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rlrr_pkg::cmd_t               cmd,
  output rlrr_pkg::stat_t              stat,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [15:0]                  cfg_data,
  input  logic [1:0]                   in_mode,
  input  logic [rlrr_pkg::IDX_W-1:0]   in_stream_index,
  input  logic [rlrr_pkg::CNT_W-1:0]   in_stream_count,
  input  logic [9:0]                   in_target_fps,
  input  logic                         in_high_priority,
  input  logic                         in_auto_degrade,
  input  logic [rlrr_pkg::TIME_W-1:0]  in_frame_time,
  input  logic [rlrr_pkg::TIME_W-1:0]  in_now,
  input  logic [15:0]                  in_elapsed_ms,
  input  logic                         in_had_results,
  output logic                         out_valid,
  output logic                         out_granted,
  output logic [rlrr_pkg::IDX_W-1:0]   out_grant_index,
  output logic [rlrr_pkg::TIME_W-1:0]  out_grant_frame_time,
  output logic                         out_clear_results,
  output logic                         out_completion_taken
);
  import rlrr_pkg::*;

  logic [15:0] ttl_r;
  logic [9:0]  dfps_r;
  logic [2:0]  maxdeg_r;

  logic [IV_W-1:0]   iv_r [MAX_STREAMS];
  logic              prio_r [MAX_STREAMS];
  logic              adapt_r [MAX_STREAMS];
  logic [TIME_W-1:0] latest_r [MAX_STREAMS];
  logic [TIME_W-1:0] taken_r [MAX_STREAMS];
  logic [TIME_W-1:0] anl_r [MAX_STREAMS];
  logic [2:0]        deg_r [MAX_STREAMS];

  logic [CNT_W-1:0]  live_r;
  logic [IDX_W-1:0]  ptr_r;
  logic [TIME_W-1:0] last_r;
  logic              pend_r;
  logic [IDX_W-1:0]  pidx_r;
  logic [TIME_W-1:0] pft_r;

  logic [1:0]        mode_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              hp_r, ad_r, had_r;
  logic [TIME_W-1:0] now_r;
  logic [15:0]       el_r;

  // divider
  logic [9:0]  dvs_r;
  logic [9:0]  quo_r;
  logic [10:0] rem_r;
  logic [3:0]  dstep_r;
  logic [10:0] rem_sh;
  logic [9:0]  fps_sel;

  // scan
  logic [CNT_W-1:0]  a_r;
  logic [IDX_W-1:0]  e_r;
  logic [IDX_W-1:0]  e_cur;
  logic [CNT_W:0]    esum;
  logic              fresh_r;
  logic [TIME_W-1:0] need_r;
  logic [IV_W-1:0]   civ_r;
  logic              cprio_r;
  logic [2:0]        cdeg_r;
  logic [TIME_W-1:0] canl_r;
  logic [TIME_W-1:0] clat_r;
  logic              cand_ok;
  logic [IDX_W-1:0]  ptr_nxt;
  logic [CNT_W-1:0]  enext;

  localparam logic [9:0] K1000 = 10'd1000;

  always_comb begin
    esum = {1'b0, ptr_r} + {1'b0, a_r};
    if (esum >= {1'b0, live_r}) begin
      esum = esum - {1'b0, live_r};
    end
    e_cur = esum[IDX_W-1:0];
    enext = {1'b0, e_r} + 4'd1;
    ptr_nxt = (enext >= live_r) ? '0 : enext[IDX_W-1:0];
    rem_sh = {rem_r[9:0], K1000[4'd9 - dstep_r]};
    cand_ok = fresh_r && ((canl_r == '0) ||
              ((now_r >= canl_r) && ((now_r - canl_r) >= need_r)));
    fps_sel = (in_target_fps != '0) ? in_target_fps :
              (dfps_r != '0) ? dfps_r : 10'd1;
  end

  assign stat.div_last = (dstep_r == 4'(DIV_STEPS - 1));
  assign stat.scan_last = (a_r >= live_r);
  assign stat.cand_ok = cand_ok;
  assign stat.pending = pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= 16'd350;
      dfps_r <= 10'd5;
      maxdeg_r <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TTL: ttl_r <= cfg_data;
        CFG_DFPS: dfps_r <= cfg_data[9:0];
        CFG_MAXDEG: maxdeg_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      mode_r <= in_mode;
      idx_r <= in_stream_index;
      cnt_r <= in_stream_count;
      hp_r <= in_high_priority;
      ad_r <= in_auto_degrade;
      now_r <= in_now;
      el_r <= in_elapsed_ms;
      had_r <= in_had_results;
      dvs_r <= fps_sel;
      quo_r <= '0;
      rem_r <= '0;
      dstep_r <= '0;
    end
    if (cmd.div_step) begin
      dstep_r <= dstep_r + 4'd1;
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_r <= rem_sh - {1'b0, dvs_r};
        quo_r <= {quo_r[8:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[8:0], 1'b0};
      end
    end
    if (cmd.scan_read) begin
      e_r <= e_cur;
      civ_r <= iv_r[e_cur];
      cprio_r <= prio_r[e_cur];
      cdeg_r <= deg_r[e_cur];
      canl_r <= anl_r[e_cur];
      clat_r <= latest_r[e_cur];
      fresh_r <= (latest_r[e_cur] != '0) && (latest_r[e_cur] != taken_r[e_cur]);
    end
    if (cmd.mul) begin
      need_r <= TIME_W'({4'd0, civ_r} * (cprio_r ? {1'b0, cdeg_r} + 4'd1 : 4'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_write && (idx_r < IDX_W'(MAX_STREAMS - 1) || idx_r == IDX_W'(MAX_STREAMS - 1))) begin
      iv_r[idx_r] <= (quo_r == '0) ? 10'd1 : quo_r;
      prio_r[idx_r] <= hp_r;
      adapt_r[idx_r] <= ad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_STREAMS; i++) begin
        latest_r[i] <= '0;
        taken_r[i] <= '0;
        anl_r[i] <= '0;
        deg_r[i] <= '0;
      end
      live_r <= '0;
      ptr_r <= '0;
      last_r <= '0;
      pend_r <= 1'b0;
      pidx_r <= '0;
      pft_r <= '0;
      a_r <= '0;
      out_valid <= 1'b0;
      out_granted <= 1'b0;
      out_grant_index <= '0;
      out_grant_frame_time <= '0;
      out_clear_results <= 1'b0;
      out_completion_taken <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      out_granted <= 1'b0;
      out_grant_index <= '0;
      out_grant_frame_time <= '0;
      out_clear_results <= 1'b0;
      out_completion_taken <= 1'b0;
      if (cmd.init) begin
        a_r <= '0;
      end
      if (cmd.frame_write) begin
        latest_r[in_stream_index] <= in_frame_time;
        out_valid <= 1'b1;
      end
      if (cmd.load_write) begin
        latest_r[idx_r] <= '0;
        taken_r[idx_r] <= '0;
        anl_r[idx_r] <= '0;
        deg_r[idx_r] <= '0;
        live_r <= (cnt_r > CNT_W'(MAX_STREAMS)) ? CNT_W'(MAX_STREAMS) : cnt_r;
        ptr_r <= '0;
        last_r <= '0;
        pend_r <= 1'b0;
        out_valid <= 1'b1;
      end
      if (cmd.check) begin
        a_r <= a_r + 4'd1;
        if (cand_ok) begin
          pend_r <= 1'b1;
          pidx_r <= e_r;
          pft_r <= clat_r;
          ptr_r <= ptr_nxt;
          out_valid <= 1'b1;
          out_granted <= 1'b1;
          out_grant_index <= e_r;
          out_grant_frame_time <= clat_r;
        end
      end
      if (cmd.expire) begin
        out_valid <= 1'b1;
        if ((last_r != '0) && (now_r > last_r) &&
            ((now_r - last_r) > {24'd0, ttl_r})) begin
          last_r <= '0;
          out_clear_results <= 1'b1;
        end
      end
      if (cmd.done) begin
        out_valid <= 1'b1;
        if (mode_r == MODE_DONE && pend_r) begin
          taken_r[pidx_r] <= pft_r;
          anl_r[pidx_r] <= now_r;
          if (adapt_r[pidx_r] && prio_r[pidx_r]) begin
            if (el_r > {6'd0, iv_r[pidx_r]}) begin
              deg_r[pidx_r] <= (deg_r[pidx_r] >= maxdeg_r) ? maxdeg_r : deg_r[pidx_r] + 3'd1;
            end else if (deg_r[pidx_r] != '0) begin
              deg_r[pidx_r] <= deg_r[pidx_r] - 3'd1;
            end
          end
          if (had_r) begin
            last_r <= now_r;
          end
          pend_r <= 1'b0;
          out_completion_taken <= 1'b1;
        end
      end
    end
  end
endmodule

### src/rate_limited_round_robin_picker.sv
// Top level of the rate limited round robin picker
// Usage: pulse start with a word on the in_ ports while busy is low; the
// word is taken at that edge. in_mode selects load entry, frame arrived,
// poll or job done. Each word yields one result word on the out_ ports,
// marked by out_valid for exactly one cycle; the receiver cannot stall.
// Steps: a frame is stored at the start edge; job done and a pending poll
// pass the done state; load runs a 10-step restoring divider for 1000 /
// fps, one quotient bit per cycle, then writes the entry; poll scans the
// entries in round robin order until one is granted, else checks the TTL;
// the scan reads one table entry and does one multiply per entry.
// Items are handled one at a time; busy is high while one is at work.
// Configuration words on cfg_ (index 0 TTL, 1 default rate, 2 degrade
// ceiling): the user writes them while busy is low; the block does not check.
// Reset (synchronous, rst_n low) clears the control state, entry times,
// degrade levels and the pending job, and loads the register defaults.
`timescale 1ns / 1ps
module rate_limited_round_robin_picker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [15:0]                  cfg_data,
  input  logic [1:0]                   in_mode,
  input  logic [rlrr_pkg::IDX_W-1:0]   in_stream_index,
  input  logic [rlrr_pkg::CNT_W-1:0]   in_stream_count,
  input  logic [9:0]                   in_target_fps,
  input  logic                         in_high_priority,
  input  logic                         in_auto_degrade,
  input  logic [rlrr_pkg::TIME_W-1:0]  in_frame_time,
  input  logic [rlrr_pkg::TIME_W-1:0]  in_now,
  input  logic [15:0]                  in_elapsed_ms,
  input  logic                         in_had_results,
  output logic                         out_valid,
  output logic                         out_granted,
  output logic [rlrr_pkg::IDX_W-1:0]   out_grant_index,
  output logic [rlrr_pkg::TIME_W-1:0]  out_grant_frame_time,
  output logic                         out_clear_results,
  output logic                         out_completion_taken
);
  import rlrr_pkg::*;
  `include "assert_macros.svh"

  cmd_t  cmd;
  stat_t stat;

  rlrr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .mode(in_mode),
    .stat(stat), .busy(busy), .cmd(cmd)
  );

  rlrr_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_mode(in_mode), .in_stream_index(in_stream_index),
    .in_stream_count(in_stream_count), .in_target_fps(in_target_fps),
    .in_high_priority(in_high_priority), .in_auto_degrade(in_auto_degrade),
    .in_frame_time(in_frame_time), .in_now(in_now),
    .in_elapsed_ms(in_elapsed_ms), .in_had_results(in_had_results),
    .out_valid(out_valid), .out_granted(out_granted),
    .out_grant_index(out_grant_index),
    .out_grant_frame_time(out_grant_frame_time),
    .out_clear_results(out_clear_results),
    .out_completion_taken(out_completion_taken)
  );

  `ASSERT_IMPLIES(a_grant_valid, clk, rst_n, out_granted, out_valid)
  `ASSERT_NEXT(a_grant_pends, clk, rst_n, out_granted, stat.pending)
  `ASSERT_IMPLIES(a_one_kind, clk, rst_n, out_valid, !(out_granted && out_clear_results))
endmodule

### bench/rate_limited_round_robin_picker_tb.sv
// Testbench for the rate limited round robin picker: directed table, then checked random traffic
`timescale 1ns / 1ps
module rate_limited_round_robin_picker_tb;
  import rlrr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [39:0] TMAX = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  idx;
    logic [3:0]  cnt;
    logic [9:0]  fps;
    logic        hp;
    logic        ad;
    logic [39:0] ftime;
    logic [39:0] now;
    logic [15:0] elapsed;
    logic        had;
  } word_t;

  typedef struct packed {
    logic        granted;
    logic [2:0]  gidx;
    logic [39:0] gft;
    logic        clr;
    logic        comp;
  } pick_t;

  typedef struct packed {
    word_t w;
    logic  typed;
    pick_t res;
  } row_t;

  logic clk, rst_n, start, busy, cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic [1:0] in_mode;
  logic [2:0] in_stream_index;
  logic [3:0] in_stream_count;
  logic [9:0] in_target_fps;
  logic in_high_priority, in_auto_degrade, in_had_results;
  logic [39:0] in_frame_time, in_now;
  logic [15:0] in_elapsed_ms;
  logic out_valid, out_granted, out_clear_results, out_completion_taken;
  logic [2:0] out_grant_index;
  logic [39:0] out_grant_frame_time;

  rate_limited_round_robin_picker u_top (.*);

  logic [15:0] ttl_reg;
  logic [9:0]  dfps_reg;
  logic [2:0]  maxdeg_reg;
  logic [9:0]  iv_tab [MAX_STREAMS];
  logic        prio_tab [MAX_STREAMS];
  logic        adapt_tab [MAX_STREAMS];
  logic [39:0] latest_tab [MAX_STREAMS];
  logic [39:0] taken_tab [MAX_STREAMS];
  logic [39:0] analyzed_tab [MAX_STREAMS];
  logic [2:0]  degrade_tab [MAX_STREAMS];
  int unsigned live_cnt, rr_ptr;
  logic [39:0] last_res_time, pend_ftime;
  logic        pend_valid;
  int unsigned pend_idx;

  pick_t picks_due[$];
  int mismatches;
  int idle_cycles;
  logic [39:0] clock_ms;
  row_t dir_rows[$];

  function automatic pick_t pick_next(word_t w);
    pick_t r;
    int unsigned f, e, up;
    logic [63:0] need, iv;
    r = '0;
    case (w.mode)
      MODE_LOAD: begin
        f = w.fps != 0 ? w.fps : (dfps_reg != 0 ? dfps_reg : 1);
        iv = 1000 / f;
        if (iv < 1) iv = 1;
        iv_tab[w.idx] = iv[9:0];
        prio_tab[w.idx] = w.hp;
        adapt_tab[w.idx] = w.ad;
        latest_tab[w.idx] = '0;
        taken_tab[w.idx] = '0;
        analyzed_tab[w.idx] = '0;
        degrade_tab[w.idx] = '0;
        live_cnt = w.cnt > MAX_STREAMS ? MAX_STREAMS : w.cnt;
        rr_ptr = 0;
        last_res_time = '0;
        pend_valid = 1'b0;
      end
      MODE_FRAME: latest_tab[w.idx] = w.ftime;
      MODE_POLL: begin
        if (pend_valid) return r;
        for (int a = 0; a < live_cnt; a++) begin
          e = (rr_ptr + a) % live_cnt;
          if (latest_tab[e] == 0 || latest_tab[e] == taken_tab[e]) continue;
          need = 64'(iv_tab[e]) * (prio_tab[e] ? 64'(degrade_tab[e]) + 1 : 64'd1);
          if (analyzed_tab[e] > 0 &&
              (w.now < analyzed_tab[e] || 64'(w.now - analyzed_tab[e]) < need)) continue;
          pend_valid = 1'b1;
          pend_idx = e;
          pend_ftime = latest_tab[e];
          rr_ptr = (e + 1) % live_cnt;
          r.granted = 1'b1;
          r.gidx = e[2:0];
          r.gft = pend_ftime;
          return r;
        end
        if (last_res_time > 0 && w.now > last_res_time &&
            (w.now - last_res_time) > 40'(ttl_reg)) begin
          last_res_time = '0;
          r.clr = 1'b1;
        end
      end
      default: begin
        if (!pend_valid) return r;
        taken_tab[pend_idx] = pend_ftime;
        analyzed_tab[pend_idx] = w.now;
        if (adapt_tab[pend_idx] && prio_tab[pend_idx]) begin
          if (w.elapsed > iv_tab[pend_idx]) begin
            up = degrade_tab[pend_idx] + 1;
            degrade_tab[pend_idx] = up > maxdeg_reg ? maxdeg_reg : up[2:0];
          end else if (degrade_tab[pend_idx] > 0) begin
            degrade_tab[pend_idx]--;
          end
        end
        if (w.had) last_res_time = w.now;
        pend_valid = 1'b0;
        r.comp = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic word_t mk(logic [1:0] m, logic [2:0] i, logic [3:0] c, logic [9:0] f,
                               logic hp, logic ad, logic [39:0] ft, logic [39:0] nw,
                               logic [15:0] el, logic hd);
    word_t w;
    w.mode = m; w.idx = i; w.cnt = c; w.fps = f; w.hp = hp; w.ad = ad;
    w.ftime = ft; w.now = nw; w.elapsed = el; w.had = hd;
    return w;
  endfunction

  function automatic void add_row(word_t w, logic typed, pick_t res);
    row_t r;
    r.w = w; r.typed = typed; r.res = res;
    dir_rows.push_back(r);
  endfunction

  function automatic pick_t pk(logic g, logic [2:0] i, logic [39:0] ft, logic c, logic d);
    pick_t p;
    p.granted = g; p.gidx = i; p.gft = ft; p.clr = c; p.comp = d;
    return p;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int unsigned k;
    w = mk(2'($urandom), 3'($urandom), 4'($urandom), 10'($urandom), 1'($urandom),
           1'($urandom), 40'({$urandom, $urandom}), 40'({$urandom, $urandom}),
           16'($urandom), 1'($urandom));
    k = $urandom_range(0, 99);
    clock_ms += $urandom_range(0, 150);
    if (k < 10) return w;
    w.ftime = clock_ms;
    w.now = clock_ms;
    w.elapsed = $urandom_range(0, 19) == 0 ? 16'hFFFF : 16'($urandom_range(0, 1200));
    if ($urandom_range(0, 19) == 0) w.ftime = '0;
    if ($urandom_range(0, 29) == 0) w.now = clock_ms - 40'($urandom_range(0, 2000));
    if (k < 15) begin
      w.mode = MODE_LOAD;
      if ($urandom_range(0, 3) != 0) w.cnt = 4'd8;
      if ($urandom_range(0, 2) == 0) w.fps = 10'($urandom_range(0, 60));
    end else if (k < 48) w.mode = MODE_POLL;
    else if (k < 78) w.mode = MODE_FRAME;
    else w.mode = MODE_DONE;
    return w;
  endfunction

  task automatic send_word(word_t w, logic typed, pick_t res);
    pick_t p;
    in_mode <= w.mode;
    in_stream_index <= w.idx;
    in_stream_count <= w.cnt;
    in_target_fps <= w.fps;
    in_high_priority <= w.hp;
    in_auto_degrade <= w.ad;
    in_frame_time <= w.ftime;
    in_now <= w.now;
    in_elapsed_ms <= w.elapsed;
    in_had_results <= w.had;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = pick_next(w);
    picks_due.push_back(typed ? res : p);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (picks_due.size() != 0 || busy) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] ttl, logic [9:0] dfps, logic [2:0] maxdeg);
    cfg_we <= 1'b1; cfg_index <= CFG_TTL; cfg_data <= ttl;
    @(posedge clk);
    cfg_index <= CFG_DFPS; cfg_data <= 16'(dfps);
    @(posedge clk);
    cfg_index <= CFG_MAXDEG; cfg_data <= 16'(maxdeg);
    @(posedge clk);
    cfg_we <= 1'b0;
    ttl_reg = ttl; dfps_reg = dfps; maxdeg_reg = maxdeg;
  endtask

  task automatic run_random(int n);
    int left, burst, gap;
    bit steady;
    left = n;
    steady = $urandom_range(0, 3) == 0;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && left > 0; b++) begin
        send_word(rand_word(), 1'b0, '0);
        left--;
      end
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    pick_t want;
    if (rst_n && out_valid) begin
      if (picks_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        want = picks_due.pop_front();
        if (out_granted !== want.granted || out_grant_index !== want.gidx ||
            out_grant_frame_time !== want.gft || out_clear_results !== want.clr ||
            out_completion_taken !== want.comp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp g=%0b i=%0d ft=%0h c=%0b d=%0b got g=%0b i=%0d ft=%0h c=%0b d=%0b",
                     $realtime, want.granted, want.gidx, want.gft, want.clr, want.comp,
                     out_granted, out_grant_index, out_grant_frame_time,
                     out_clear_results, out_completion_taken);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_mode = '0; in_stream_index = '0; in_stream_count = '0; in_target_fps = '0;
    in_high_priority = 1'b0; in_auto_degrade = 1'b0; in_frame_time = '0; in_now = '0;
    in_elapsed_ms = '0; in_had_results = 1'b0;
    mismatches = 0; clock_ms = 40'd5000;
    ttl_reg = 16'd350; dfps_reg = 10'd5; maxdeg_reg = 3'd3;
    live_cnt = 0; rr_ptr = 0; last_res_time = '0; pend_valid = 1'b0;
    pend_idx = 0; pend_ftime = '0;
    for (int i = 0; i < MAX_STREAMS; i++) begin
      iv_tab[i] = '0; prio_tab[i] = 1'b0; adapt_tab[i] = 1'b0; latest_tab[i] = '0;
      taken_tab[i] = '0; analyzed_tab[i] = '0; degrade_tab[i] = '0;
    end

    add_row(mk(MODE_POLL, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, pk(0, 0, 0, 0, 0));
    add_row(mk(MODE_DONE, 0, 0, 0, 0, 0, 0, 40'd10, 16'd5, 1), 1, pk(0, 0, 0, 0, 0));
    add_row(mk(MODE_LOAD, 0, 4'd15, 10'd0, 1, 1, 0, 0, 0, 0), 1, pk(0, 0, 0, 0, 0));
    add_row(mk(MODE_LOAD, 1, 4'd8, 10'd1023, 1, 1, 0, 0, 0, 0), 1, pk(0, 0, 0, 0, 0));
    add_row(mk(MODE_LOAD, 2, 4'd8, 10'd1, 0, 1, 0, 0, 0, 0), 1, pk(0, 0, 0, 0, 0));
    add_row(mk(MODE_LOAD, 3, 4'd8, 10'd500, 1, 0, 0, 0, 0, 0), 1, pk(0, 0, 0, 0, 0));
    add_row(mk(MODE_LOAD, 4, 4'd8, 10'd30, 1, 1, 0, 0, 0, 0), 1, pk(0, 0, 0, 0, 0));
    add_row(mk(MODE_LOAD, 5, 4'd8, 10'd10, 0, 0, 0, 0, 0, 0), 1, pk(0, 0, 0, 0, 0));
    add_row(mk(MODE_LOAD, 6, 4'd8, 10'd682, 1, 1, 0, 0, 0, 0), 1, pk(0, 0, 0, 0, 0));
    add_row(mk(MODE_LOAD, 7, 4'd8, 10'd341, 1, 1, 0, 0, 0, 0), 1, pk(0, 0, 0, 0, 0));
    add_row(mk(MODE_FRAME, 7, 0, 0, 0, 0, TMAX, 0, 0, 0), 1, pk(0, 0, 0, 0, 0));
    add_row(mk(MODE_FRAME, 0, 0, 0, 0, 0, 40'd0, 0, 0, 0), 1, pk(0, 0, 0, 0, 0));
    add_row(mk(MODE_POLL, 0, 0, 0, 0, 0, 0, TMAX, 0, 0), 1, pk(1, 7, TMAX, 0, 0));
    add_row(mk(MODE_POLL, 0, 0, 0, 0, 0, 0, TMAX, 0, 0), 1, pk(0, 0, 0, 0, 0));
    add_row(mk(MODE_DONE, 0, 0, 0, 0, 0, 0, 40'd1000, 16'hFFFF, 1), 1, pk(0, 0, 0, 0, 1));
    add_row(mk(MODE_POLL, 0, 0, 0, 0, 0, 0, 40'd1000, 0, 0), 0, '0);
    add_row(mk(MODE_POLL, 0, 0, 0, 0, 0, 0, TMAX, 0, 0), 1, pk(0, 0, 0, 1, 0));
    add_row(mk(MODE_FRAME, 7, 0, 0, 0, 0, 40'd5, 0, 0, 0), 0, '0);
    add_row(mk(MODE_FRAME, 4, 0, 0, 0, 0, 40'd7, 0, 0, 0), 0, '0);
    add_row(mk(MODE_POLL, 0, 0, 0, 0, 0, 0, 40'd500, 0, 0), 0, '0);
    add_row(mk(MODE_DONE, 0, 0, 0, 0, 0, 0, 40'd20, 16'd0, 0), 0, '0);
    add_row(mk(MODE_POLL, 0, 0, 0, 0, 0, 0, 40'd10, 0, 0), 0, '0);
    add_row(mk(MODE_DONE, 0, 0, 0, 0, 0, 0, 40'd30, 16'd900, 1), 0, '0);
    add_row(mk(MODE_POLL, 0, 0, 0, 0, 0, 0, 40'd600, 0, 0), 0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) send_word(dir_rows[r].w, dir_rows[r].typed, dir_rows[r].res);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_regs(16'd350, 10'd5, 3'd3);
        1: write_regs(16'd0, 10'd1023, 3'd7);
        2: write_regs(16'hFFFF, 10'd0, 3'd0);
        3: write_regs(16'($urandom), 10'd1, 3'd7);
        default: write_regs(16'd20, 10'($urandom_range(1, 1023)), 3'd1);
      endcase
      run_random(140);
      drain();
      run_random(140);
      drain();
    end

    if (picks_due.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+src
src/rlrr_pkg.sv
src/rlrr_ctrl.sv
src/rlrr_dp.sv
src/rate_limited_round_robin_picker.sv
bench/rate_limited_round_robin_picker_tb.sv
